[design/sbs_pkg.sv]
// Package for the scan background segmenter: sizes, register indexes and shared types.
// No dependencies; imported by the segmenter top level and its testbench.
package sbs_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int DIST_W      = 16;
    localparam int COUNT_W     = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_THRESHOLD = 1'b0,
        CFG_MIN_SUPPORT      = 1'b1
    } cfg_index_t;

    localparam logic [DIST_W-1:0]  THRESHOLD_RESET   = DIST_W'(100);
    localparam logic [COUNT_W-1:0] MIN_SUPPORT_RESET = COUNT_W'(1);

    // control word carried from the issue stage to the compare stage
    typedef struct packed {
        logic clr_before;  // first sample of a scan: drop any open run
        logic compare;     // sample is checked against the background
        logic clr_after;   // last sample of the scan: drop the open run
    } stage_ctrl_t;

endpackage

[design/scan_background_segmenter_unit.sv]
// Top level of the scan background segmenter: scan sequencing, background RAM,
// run tracking and a two-word result queue. Depends on sbs_pkg and sbs_ram.
//
// Input channel (in_valid/in_ready): one range sample per word with its first_sample,
// scan_count and learn_background flags. A scan whose first sample has learn_background
// set is written into the background RAM; other scans of matching length are compared
// against it sample by sample.
// Output channel (out_valid/out_ready): one word per run of more than min_support detecting
// samples, closed by a non-detecting sample: nearest sample's index, range and run length.
// Config channel (cfg_valid/cfg_ready) is always ready; index 0 writes detect_threshold,
// index 1 writes min_support. Write only while idle.
// Timing: one sample per cycle sustained while in_ready is high. The edge that takes a
// sample also starts the background RAM read. Compare and run update happen in the next
// cycle, and the result word is queued at the edge after that. out_valid rises once the
// word is queued, and the word leaves on an edge where out_ready is high.
// Reset: thresholds return to 100 and 1, no background is valid, no scan is open; the
// background RAM is not cleared, and only entries of a completed learning scan are read.
// Stall: results queue in two entries. in_ready drops only when the queue plus the word in
// the compare stage could overflow; a pop in the same cycle frees a slot. Nothing is lost.
module scan_background_segmenter_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sbs_pkg::DIST_W-1:0]   distance,
    input  logic                         first_sample,
    input  logic [sbs_pkg::COUNT_W-1:0]  scan_count,
    input  logic                         learn_background,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sbs_pkg::ADDR_W-1:0]   target_index,
    output logic [sbs_pkg::DIST_W-1:0]   target_distance,
    output logic [sbs_pkg::COUNT_W-1:0]  run_length,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbs_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sbs_pkg::*;

    // configuration
    logic [DIST_W-1:0]  thr_reg;
    logic [COUNT_W-1:0] min_support_reg;

    // scan sequencing state
    logic [COUNT_W-1:0] scan_len_reg, scan_len_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic               in_scan_reg, in_scan_next;
    logic               learning_reg, learning_next;
    logic               bg_valid_reg, bg_valid_next;
    logic [COUNT_W-1:0] bg_len_reg, bg_len_next;

    // issue stage combinational
    logic               accept;
    logic [COUNT_W-1:0] sat_count;
    logic               ram_we;
    stage_ctrl_t        s0_ctrl;

    // compare stage
    logic               s1_valid_reg;
    stage_ctrl_t        s1_ctrl_reg;
    logic [DIST_W-1:0]  s1_dist_reg;
    logic [ADDR_W-1:0]  s1_pos_reg;
    logic [DIST_W-1:0]  bg_rdata;

    // run tracking
    logic [COUNT_W-1:0] run_len_reg, run_len_next;
    logic [DIST_W-1:0]  run_min_dist_reg, run_min_dist_next;
    logic [ADDR_W-1:0]  run_min_idx_reg, run_min_idx_next;
    logic [COUNT_W-1:0] run_len_cur;
    logic [DIST_W:0]    diff;
    logic               detect;
    logic               emit;

    // result queue
    logic [ADDR_W-1:0]  q_idx_reg  [2];
    logic [DIST_W-1:0]  q_dist_reg [2];
    logic [COUNT_W-1:0] q_len_reg  [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic               pop;

    assign pop       = out_valid && out_ready;
    assign in_ready  = (cnt_reg + 2'(s1_valid_reg)) <= (2'd1 + 2'(pop));
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= THRESHOLD_RESET;
            min_support_reg <= MIN_SUPPORT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DETECT_THRESHOLD: thr_reg <= cfg_data;
                CFG_MIN_SUPPORT:      min_support_reg <= cfg_data[COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    // ---------------- issue stage: scan bookkeeping, RAM write or read ----------------
    assign sat_count = (scan_count > COUNT_W'(MAX_SAMPLES)) ? COUNT_W'(MAX_SAMPLES)
                                                            : scan_count;

    always_comb
    begin
        scan_len_next = scan_len_reg;
        pos_next      = pos_reg;
        in_scan_next  = in_scan_reg;
        learning_next = learning_reg;
        bg_valid_next = bg_valid_reg;
        bg_len_next   = bg_len_reg;
        ram_we        = 1'b0;
        s0_ctrl       = '0;

        if (accept)
        begin
            if (first_sample)
            begin
                scan_len_next      = sat_count;
                pos_next           = '0;
                learning_next      = learn_background;
                in_scan_next       = sat_count != '0;
                s0_ctrl.clr_before = 1'b1;
                if (learn_background)
                begin
                    bg_valid_next = 1'b0;
                    bg_len_next   = sat_count;
                end
            end
            if (in_scan_next)
            begin
                if (learning_next)
                begin
                    ram_we = 1'b1;
                    if ({1'b0, pos_next} + COUNT_W'(1) == scan_len_next)
                    begin
                        bg_valid_next = 1'b1;
                        learning_next = 1'b0;
                    end
                end
                else
                begin
                    s0_ctrl.compare = bg_valid_next && (bg_len_next == scan_len_next);
                end
                if ({1'b0, pos_next} + COUNT_W'(1) >= scan_len_next)
                begin
                    in_scan_next      = 1'b0;
                    s0_ctrl.clr_after = 1'b1;
                end
                pos_next = pos_next + ADDR_W'(1);
            end
        end
    end

    // first_sample resets position to zero before the RAM address is formed
    logic [ADDR_W-1:0] ram_addr;
    assign ram_addr = first_sample ? '0 : pos_reg;

    sbs_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_SAMPLES)
    ) u_bg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (distance),
        .raddr (ram_addr),
        .rdata (bg_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_len_reg <= '0;
            pos_reg      <= '0;
            in_scan_reg  <= 1'b0;
            learning_reg <= 1'b0;
            bg_valid_reg <= 1'b0;
            bg_len_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
        end
        else
        begin
            scan_len_reg <= scan_len_next;
            pos_reg      <= pos_next;
            in_scan_reg  <= in_scan_next;
            learning_reg <= learning_next;
            bg_valid_reg <= bg_valid_next;
            bg_len_reg   <= bg_len_next;
            s1_valid_reg <= accept;
            s1_ctrl_reg  <= s0_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dist_reg <= distance;
            s1_pos_reg  <= ram_addr;
        end
    end

    // ---------------- compare stage: detect and run update ----------------
    assign diff   = {1'b0, bg_rdata} - {1'b0, s1_dist_reg};
    // borrow set means range beyond background: never a detection
    assign detect = !diff[DIST_W] && (diff[DIST_W-1:0] > thr_reg);

    always_comb
    begin
        run_len_cur       = s1_ctrl_reg.clr_before ? '0 : run_len_reg;
        run_len_next      = run_len_reg;
        run_min_dist_next = run_min_dist_reg;
        run_min_idx_next  = run_min_idx_reg;
        emit              = 1'b0;

        if (s1_valid_reg)
        begin
            run_len_next = run_len_cur;
            if (s1_ctrl_reg.compare)
            begin
                if (detect)
                begin
                    if (run_len_cur == '0 || s1_dist_reg < run_min_dist_reg)
                    begin
                        run_min_dist_next = s1_dist_reg;
                        run_min_idx_next  = s1_pos_reg;
                    end
                    run_len_next = run_len_cur + COUNT_W'(1);
                end
                else if (run_len_cur != '0)
                begin
                    emit         = run_len_cur > min_support_reg;
                    run_len_next = '0;
                end
            end
            if (s1_ctrl_reg.clr_after)
            begin
                run_len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg <= '0;
        end
        else
        begin
            run_len_reg <= run_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_min_dist_reg <= run_min_dist_next;
        run_min_idx_reg  <= run_min_idx_next;
    end

    // ---------------- result queue ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (emit)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(emit) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            q_idx_reg[wr_ptr_reg]  <= run_min_idx_reg;
            q_dist_reg[wr_ptr_reg] <= run_min_dist_reg;
            q_len_reg[wr_ptr_reg]  <= run_len_cur;
        end
    end

    assign out_valid       = cnt_reg != '0;
    assign target_index    = q_idx_reg[rd_ptr_reg];
    assign target_distance = q_dist_reg[rd_ptr_reg];
    assign run_length      = q_len_reg[rd_ptr_reg];

    // ---------------- checks ----------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("result queue overflow");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |-> !emit)
        else $error("result pushed into full queue");

    a_write_xor_compare: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && s0_ctrl.compare))
        else $error("background write and compare on one sample");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_len_reg <= COUNT_W'(MAX_SAMPLES))
        else $error("open run longer than a scan");

endmodule

[design/sbs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[verif/tb_scan_background_segmenter_unit.sv]
// Testbench for scan_background_segmenter_unit: a directed table, then phased random scans.
// Every result word is checked against an in-bench model of the segmenter or a table row.
// Depends on sbs_pkg and the design sources only.
module tb_scan_background_segmenter_unit;
    import sbs_pkg::*;

    localparam int DIR_ROWS     = 25;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 72;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [ADDR_W-1:0]  index;
        logic [DIST_W-1:0]  range_mm;
        logic [COUNT_W-1:0] length;
    } target_t;

    typedef enum logic [1:0] { CHK_MODEL, CHK_NONE, CHK_HIT } row_check_t;

    typedef struct packed {
        row_check_t         check;
        logic [DIST_W-1:0]  range_mm;
        logic               first;
        logic [COUNT_W-1:0] count;
        logic               learn;
        target_t            target;
    } stim_row_t;

    // Background learned as 1000 1000 65535 65535 500 0, then compared at the reset settings.
    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{CHK_NONE,  16'd0,     1'b0, 11'd0,    1'b0, '0},  // no scan open yet
        '{CHK_NONE,  16'd0,     1'b1, 11'd0,    1'b0, '0},  // empty scan
        '{CHK_NONE,  16'd65535, 1'b0, 11'd2047, 1'b1, '0},  // still nothing open
        '{CHK_MODEL, 16'd1000,  1'b1, 11'd6,    1'b1, '0},
        '{CHK_MODEL, 16'd1000,  1'b0, 11'd0,    1'b0, '0},
        '{CHK_MODEL, 16'd65535, 1'b0, 11'd0,    1'b0, '0},
        '{CHK_MODEL, 16'd65535, 1'b0, 11'd0,    1'b0, '0},
        '{CHK_MODEL, 16'd500,   1'b0, 11'd0,    1'b0, '0},
        '{CHK_MODEL, 16'd0,     1'b0, 11'd0,    1'b0, '0},
        '{CHK_NONE,  16'd12345, 1'b0, 11'd0,    1'b0, '0},  // past end of scan
        '{CHK_MODEL, 16'd900,   1'b1, 11'd6,    1'b0, '0},  // diff equals threshold
        '{CHK_MODEL, 16'd899,   1'b0, 11'd0,    1'b0, '0},
        '{CHK_MODEL, 16'd0,     1'b0, 11'd0,    1'b0, '0},
        '{CHK_MODEL, 16'd0,     1'b0, 11'd0,    1'b0, '0},  // tie keeps the earlier index
        '{CHK_HIT,   16'd65535, 1'b0, 11'd0,    1'b0, '{10'd2, 16'd0, 11'd3}},
        '{CHK_MODEL, 16'd0,     1'b0, 11'd0,    1'b0, '0},
        '{CHK_MODEL, 16'd0,     1'b1, 11'd6,    1'b0, '0},
        '{CHK_MODEL, 16'd1000,  1'b0, 11'd0,    1'b0, '0},  // run of one, not reported
        '{CHK_MODEL, 16'd65534, 1'b0, 11'd0,    1'b0, '0},
        '{CHK_MODEL, 16'd0,     1'b0, 11'd0,    1'b0, '0},
        '{CHK_MODEL, 16'd0,     1'b0, 11'd0,    1'b0, '0},
        '{CHK_HIT,   16'd0,     1'b0, 11'd0,    1'b0, '{10'd3, 16'd0, 11'd2}},
        '{CHK_MODEL, 16'd0,     1'b1, 11'd6,    1'b0, '0},
        '{CHK_MODEL, 16'd0,     1'b0, 11'd0,    1'b0, '0},
        '{CHK_MODEL, 16'd0,     1'b1, 11'd2000, 1'b0, '0}   // run cut off, count saturates
    };

    logic                  clk;
    logic                  rst_n            = 1'b0;
    logic                  in_valid         = 1'b0;
    logic                  in_ready;
    logic [DIST_W-1:0]     distance         = '0;
    logic                  first_sample     = 1'b0;
    logic [COUNT_W-1:0]    scan_count       = '0;
    logic                  learn_background = 1'b0;
    logic                  out_valid;
    logic                  out_ready        = 1'b0;
    logic [ADDR_W-1:0]     target_index;
    logic [DIST_W-1:0]     target_distance;
    logic [COUNT_W-1:0]    run_length;
    logic                  cfg_valid        = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index        = CFG_DETECT_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data         = '0;

    // segmenter model state
    logic [DIST_W-1:0]  thr_reg     = THRESHOLD_RESET;
    logic [COUNT_W-1:0] support_reg = MIN_SUPPORT_RESET;
    logic [DIST_W-1:0]  bg_ram [MAX_SAMPLES];
    logic [COUNT_W-1:0] bg_len      = '0;
    logic               bg_ok       = 1'b0;
    logic               learning    = 1'b0;
    logic [COUNT_W-1:0] pos         = '0;
    logic [COUNT_W-1:0] run_len     = '0;
    logic [DIST_W-1:0]  run_min     = '0;
    logic [ADDR_W-1:0]  run_idx     = '0;
    logic               scanning    = 1'b0;
    logic [COUNT_W-1:0] scan_len    = '0;

    target_t targets_due [$];
    int      errors = 0;
    int      taken  = 0;

    // stimulus side view of the background it has taught
    logic [DIST_W-1:0] learned [MAX_SAMPLES];
    int                learned_len = 0;
    bit                learned_ok  = 1'b0;
    bit                scan_open   = 1'b1;
    int                gen_thr     = THRESHOLD_RESET;
    int                idle_odds   = 3;
    int                items_sent  = 0;
    int                stall_left  = 0;

    scan_background_segmenter_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .distance         (distance),
        .first_sample     (first_sample),
        .scan_count       (scan_count),
        .learn_background (learn_background),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .target_index     (target_index),
        .target_distance  (target_distance),
        .run_length       (run_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("status: fail");
        $finish;
    end

    // Advance the model by one accepted sample; returns 1 when a run is reported.
    function automatic bit segment_sample(input logic [DIST_W-1:0] d, input logic first,
                                          input logic [COUNT_W-1:0] count, input logic learn,
                                          output target_t hit);
        logic [COUNT_W-1:0] len;
        logic [COUNT_W-1:0] p;
        int                 diff;
        bit                 found;
        len   = (count > COUNT_W'(MAX_SAMPLES)) ? COUNT_W'(MAX_SAMPLES) : count;
        found = 1'b0;
        hit   = '0;
        if (first)
        begin
            scan_len = len;
            pos      = '0;
            run_len  = '0;
            learning = learn;
            scanning = (len != 0);
            if (learn)
            begin
                bg_ok  = 1'b0;
                bg_len = len;
            end
        end
        if (!scanning || pos >= scan_len)
            return 1'b0;
        p = pos;
        if (learning)
        begin
            bg_ram[p[ADDR_W-1:0]] = d;
            if (p + 1 == scan_len)
            begin
                bg_ok    = 1'b1;
                learning = 1'b0;
            end
        end
        else if (bg_ok && bg_len == scan_len)
        begin
            diff = int'(bg_ram[p[ADDR_W-1:0]]) - int'(d);
            if (diff > int'(thr_reg))
            begin
                if (run_len == 0 || d < run_min)
                begin
                    run_min = d;
                    run_idx = p[ADDR_W-1:0];
                end
                run_len = run_len + 1'b1;
            end
            else if (run_len != 0)
            begin
                if (run_len > support_reg)
                begin
                    hit   = '{run_idx, run_min, run_len};
                    found = 1'b1;
                end
                run_len = '0;
            end
        end
        pos = p + 1'b1;
        if (pos >= scan_len)
        begin
            scanning = 1'b0;
            run_len  = '0;
        end
        return found;
    endfunction

    always @(posedge clk)
    begin : watch
        target_t hit;
        target_t want;
        bit      found;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DETECT_THRESHOLD: thr_reg = cfg_data;
                    CFG_MIN_SUPPORT:      support_reg = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                found = segment_sample(distance, first_sample, scan_count, learn_background,
                                       hit);
                if (taken < DIR_ROWS && dir_rows[taken].check != CHK_MODEL)
                begin
                    found = (dir_rows[taken].check == CHK_HIT);
                    hit   = dir_rows[taken].target;
                end
                if (found)
                    targets_due = {targets_due, hit};
                taken++;
            end
            if (out_valid && out_ready)
            begin
                if (targets_due.size() == 0)
                begin
                    $error("result word with none due: index %0d distance %0d length %0d",
                           target_index, target_distance, run_length);
                    errors++;
                end
                else
                begin
                    want = targets_due.pop_front();
                    if (target_index !== want.index)
                    begin
                        $error("target_index: expected %0d, actual %0d",
                               want.index, target_index);
                        errors++;
                    end
                    if (target_distance !== want.range_mm)
                    begin
                        $error("target_distance: expected %0d, actual %0d",
                               want.range_mm, target_distance);
                        errors++;
                    end
                    if (run_length !== want.length)
                    begin
                        $error("run_length: expected %0d, actual %0d",
                               want.length, run_length);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver back-pressure: out_ready dropped in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_odds != 0 && $urandom_range(idle_odds * 2 - 1) == 0)
        begin
            stall_left <= $urandom_range(5, 0);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_sample(input logic [DIST_W-1:0] d, input logic first,
                               input logic [COUNT_W-1:0] count, input logic learn);
        if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        distance         <= d;
        first_sample     <= first;
        scan_count       <= count;
        learn_background <= learn;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // non-first word: count and learn flag carry noise the block must ignore
    task automatic send_follow(input logic [DIST_W-1:0] d);
        send_sample(d, 1'b0, COUNT_W'($urandom), 1'($urandom));
    endtask

    task automatic write_settings(input logic [DIST_W-1:0] thr, input logic [COUNT_W-1:0] ms);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DETECT_THRESHOLD;
        cfg_data  <= thr;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_MIN_SUPPORT;
        cfg_data  <= CFG_DATA_W'(ms);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_thr = thr;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (targets_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // range that lands just inside, well inside, or outside the detection band
    function automatic logic [DIST_W-1:0] pick_distance(input logic [DIST_W-1:0] bgv,
                                                         input int thr, input bit hit);
        int cut;
        cut = int'(bgv) - thr;   // detecting ranges lie strictly below cut
        if (hit && cut > 0)
        begin
            case ($urandom_range(3))
                0:       return DIST_W'(cut - 1);
                1:       return '0;
                default: return DIST_W'($urandom_range(cut - 1, 0));
            endcase
        end
        if (cut < 0)
            return DIST_W'($urandom);
        if ($urandom_range(3) == 0)
            return DIST_W'(cut);
        return DIST_W'($urandom_range(65535, cut));
    endfunction

    task automatic send_learn_scan(input logic [COUNT_W-1:0] count, input int n_send,
                                   input int lo);
        int                eff;
        logic [DIST_W-1:0] v;
        eff = (count > COUNT_W'(MAX_SAMPLES)) ? MAX_SAMPLES : int'(count);
        for (int i = 0; i < n_send; i++)
        begin
            case ($urandom_range(7))
                0:       v = '0;
                1:       v = '1;
                2:       v = DIST_W'($urandom);
                default: v = DIST_W'($urandom_range(65535, lo));
            endcase
            if (i < eff)
                learned[i] = v;
            if (i == 0)
                send_sample(v, 1'b1, count, 1'b1);
            else
                send_follow(v);
        end
        learned_len = eff;
        learned_ok  = (eff != 0) && (n_send >= eff);
        scan_open   = (n_send < eff);
    endtask

    task automatic send_compare_scan(input int n_send, input bit long_run);
        int                run_left;
        bit                hit;
        logic [DIST_W-1:0] v;
        run_left = 0;
        for (int i = 0; i < n_send; i++)
        begin
            if (run_left == 0 && $urandom_range(9) < 3)
                run_left = ($urandom_range(9) == 0) ? $urandom_range(40, 7)
                                                    : $urandom_range(6, 1);
            hit = (run_left != 0) || (long_run && i >= 100 && i < 700);
            if (run_left != 0)
                run_left--;
            v = pick_distance(learned[i], gen_thr, hit);
            if (i == 0)
                send_sample(v, 1'b1, COUNT_W'(learned_len), 1'b0);
            else
                send_follow(v);
        end
        scan_open = (n_send < learned_len);
    endtask

    task automatic next_scan();
        int pick;
        int cnt;
        pick = $urandom_range(99);
        if (!learned_ok || pick < 14)
        begin
            cnt = $urandom_range(40, 1);
            send_learn_scan(COUNT_W'(cnt), cnt, 1500);
        end
        else if (pick < 72)
        begin
            send_compare_scan(learned_len, 1'b0);
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(3, 1)) send_follow(DIST_W'($urandom));
        end
        else if (pick < 80 && learned_len > 1)
            send_compare_scan($urandom_range(learned_len - 1, 1), 1'b0);  // cut short
        else if (pick < 86)
        begin
            // learning aborted by the next first sample
            cnt = $urandom_range(40, 2);
            send_learn_scan(COUNT_W'(cnt), $urandom_range(cnt - 1, 1), 1500);
        end
        else if (pick < 94)
        begin
            // length differs from the background: never compared
            cnt = $urandom_range(40, 1);
            if (cnt == learned_len)
                cnt++;
            send_sample(DIST_W'($urandom), 1'b1, COUNT_W'(cnt), 1'b0);
            repeat (cnt - 1) send_follow(DIST_W'($urandom));
            scan_open = 1'b0;
        end
        else if (pick < 97 && !scan_open)
            repeat ($urandom_range(3, 1)) send_follow(DIST_W'($urandom));
        else
        begin
            // empty scan; with learn set it also drops the background
            cnt = $urandom_range(1);
            send_sample(DIST_W'($urandom), 1'b1, '0, 1'(cnt));
            if (cnt != 0)
                learned_ok = 1'b0;
            scan_open = 1'b0;
            repeat ($urandom_range(2)) send_follow(DIST_W'($urandom));
        end
    endtask

    initial
    begin : stimulus
        logic [DIST_W-1:0]  thr;
        logic [COUNT_W-1:0] ms;
        int                 start;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_sample(dir_rows[r].range_mm, dir_rows[r].first, dir_rows[r].count,
                        dir_rows[r].learn);
        learned[0]  = 16'd1000;
        learned[1]  = 16'd1000;
        learned[2]  = 16'd65535;
        learned[3]  = 16'd65535;
        learned[4]  = 16'd500;
        learned[5]  = 16'd0;
        learned_len = 6;
        learned_ok  = 1'b1;
        drain_results();

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    thr = '0;
                    ms  = '0;
                end
                2:
                begin
                    thr = '1;
                    ms  = COUNT_W'(1);
                end
                3:
                begin
                    thr = DIST_W'($urandom_range(3000, 0));
                    ms  = COUNT_W'(MAX_SAMPLES);
                end
                4:
                begin
                    thr = DIST_W'($urandom_range(1000, 200));
                    ms  = COUNT_W'(2);
                end
                N_PHASES - 1:
                begin
                    thr = THRESHOLD_RESET;
                    ms  = MIN_SUPPORT_RESET;
                end
                default:
                begin
                    thr = DIST_W'($urandom_range(3000, 0));
                    ms  = COUNT_W'($urandom_range(6, 0));
                end
            endcase
            write_settings(thr, ms);
            case ($urandom_range(2))
                0:       idle_odds = 0;
                1:       idle_odds = 3;
                default: idle_odds = 8;
            endcase
            if (phase == N_PHASES - 1)
                idle_odds = 0;
            if (phase == 4)
            begin
                // oversized learn count saturates; cut short, so the background stays invalid
                send_learn_scan(11'h7FF, 24, 20000);
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                next_scan();
            drain_results();
        end

        if (errors == 0 && targets_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
